[rtl/mket_pkg.sv]
// ----------------------------------------------------------------------------
// mket_pkg
// Shared types, codes and helpers for the key-matrix event translator.
// ----------------------------------------------------------------------------
package mket_pkg;

   localparam int CMD_W      = 2;
   localparam int CODE_W     = 8;
   localparam int KEY_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int MAP_IDX_W  = 7;
   localparam int KIND_W     = 3;
   localparam int GPIO_W     = 5;
   localparam int LEVEL_W    = 7;
   localparam int TICK_W     = 9;
   localparam int CNT_W      = 4;
   localparam int FLAGS_W    = 4;
   localparam int CAPS_W     = 14;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam int IDX_W      = 8;   // wide enough for row*columns+column

   localparam int KEYS_PER_ROW_CODE = 10;
   localparam int DEF_MAX_ROWS      = 8;
   localparam int DEF_REPEAT_TICKS  = 300;

   // commands
   localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GPIO    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RAW     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BRIGHT  = 3'd4;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_ROWS   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COLS   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SYMBOL = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CAPS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ALT    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BKSP   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_BRIGHT = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd7;

   // mode flag bits
   localparam int FLAG_HAS_SYMBOL = 0;
   localparam int FLAG_REPEAT     = 1;
   localparam int FLAG_RAW        = 2;
   localparam int FLAG_BACKLIGHT  = 3;

   localparam logic [CHAR_W-1:0]  CHAR_NULL  = 8'h00;
   localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0]  CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0]  CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0]  CASE_DIFF  = 8'h20;
   localparam logic [KEY_W-1:0]   GPIO_LAST_KEY = 7'd96;
   localparam logic [KEY_W-1:0]   GPIO_BASE     = 7'd97;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 7'd127;
   localparam logic [TICK_W-1:0]  TICK_MAX      = 9'd511;

   typedef struct packed {
      logic [CNT_W-1:0]   row_count;
      logic [CNT_W-1:0]   column_count;
      logic [KEY_W-1:0]   symbol_key;
      logic [CAPS_W-1:0]  caps_keys;
      logic [KEY_W-1:0]   alt_key;
      logic [KEY_W-1:0]   backspace_key;
      logic [KEY_W-1:0]   brightness_key;
      logic [FLAGS_W-1:0] mode_flags;
   } cfg_type;

   // word held while the keymap read is in flight
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CODE_W-1:0] code;
      logic [KEY_W-1:0]  key;       // key code minus one
      logic              row_ok;
      logic              look_ok;
   } stage_type;

   typedef struct packed {
      logic               valid;
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  char_code;
      logic               is_pressed;
      logic [GPIO_W-1:0]  gpio_index;
      logic [KEY_W-1:0]   raw_key;
      logic [LEVEL_W-1:0] brightness;
   } result_type;

   // key / 10 for keys below 128: multiply by 205, shift by 11
   function automatic logic [CNT_W-1:0] div10(input logic [KEY_W-1:0] k);
      logic [15:0] prod;
      prod = 16'(k) * 16'd205;
      return prod[14:11];
   endfunction

endpackage

[rtl/mket_if.sv]
// ----------------------------------------------------------------------------
// mket_req_if / mket_rsp_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface mket_req_if;
   import mket_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [CODE_W-1:0]    event_code;
   logic                 map_select;
   logic [MAP_IDX_W-1:0] map_index;
   logic [CHAR_W-1:0]    map_char;

   modport source (output valid, cmd, event_code, map_select, map_index, map_char,
                   input ready);
   modport sink   (input valid, cmd, event_code, map_select, map_index, map_char,
                   output ready);
endinterface

interface mket_rsp_if;
   import mket_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CHAR_W-1:0]  char_code;
   logic               is_pressed;
   logic [GPIO_W-1:0]  gpio_index;
   logic [KEY_W-1:0]   raw_key;
   logic [LEVEL_W-1:0] brightness;

   modport source (output valid, kind, char_code, is_pressed, gpio_index, raw_key,
                   brightness, input ready);
   modport sink   (input valid, kind, char_code, is_pressed, gpio_index, raw_key,
                   brightness, output ready);
endinterface

[rtl/mket_csr.sv]
// ----------------------------------------------------------------------------
// mket_csr
// APB-style register file holding the matrix geometry, key roles and modes.
// ----------------------------------------------------------------------------
module mket_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mket_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [mket_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [mket_pkg::APB_DATA_W-1:0]  prdata,
   output logic                             pready,
   output mket_pkg::cfg_type                cfg
);
   import mket_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = paddr[APB_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ROWS:   cfg_in.row_count      = pwdata[CNT_W-1:0];
            REG_COLS:   cfg_in.column_count   = pwdata[CNT_W-1:0];
            REG_SYMBOL: cfg_in.symbol_key     = pwdata[KEY_W-1:0];
            REG_CAPS:   cfg_in.caps_keys      = pwdata[CAPS_W-1:0];
            REG_ALT:    cfg_in.alt_key        = pwdata[KEY_W-1:0];
            REG_BKSP:   cfg_in.backspace_key  = pwdata[KEY_W-1:0];
            REG_BRIGHT: cfg_in.brightness_key = pwdata[KEY_W-1:0];
            REG_MODE:   cfg_in.mode_flags     = pwdata[FLAGS_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{row_count: CNT_W'(4), column_count: CNT_W'(10), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ROWS:   prdata = APB_DATA_W'(cfg_ff.row_count);
         REG_COLS:   prdata = APB_DATA_W'(cfg_ff.column_count);
         REG_SYMBOL: prdata = APB_DATA_W'(cfg_ff.symbol_key);
         REG_CAPS:   prdata = APB_DATA_W'(cfg_ff.caps_keys);
         REG_ALT:    prdata = APB_DATA_W'(cfg_ff.alt_key);
         REG_BKSP:   prdata = APB_DATA_W'(cfg_ff.backspace_key);
         REG_BRIGHT: prdata = APB_DATA_W'(cfg_ff.brightness_key);
         REG_MODE:   prdata = APB_DATA_W'(cfg_ff.mode_flags);
         default:    prdata = '0;
      endcase
   end

endmodule

[rtl/mket_keymap.sv]
// ----------------------------------------------------------------------------
// mket_keymap
// Character and symbol maps: one write port, both maps read at one index,
// read data registered.
// ----------------------------------------------------------------------------
module mket_keymap #(
   parameter int DEPTH = mket_pkg::DEF_MAX_ROWS * mket_pkg::KEYS_PER_ROW_CODE,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         wr_sel,   // 1: symbol map
   input  logic [AW-1:0]                wr_addr,
   input  logic [mket_pkg::CHAR_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [mket_pkg::CHAR_W-1:0]  char_q,
   output logic [mket_pkg::CHAR_W-1:0]  sym_q
);
   import mket_pkg::*;

   logic [CHAR_W-1:0] char_mem [DEPTH];
   logic [CHAR_W-1:0] sym_mem  [DEPTH];
   logic [CHAR_W-1:0] char_q_ff;
   logic [CHAR_W-1:0] sym_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel) begin
         char_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_sel) begin
         sym_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         char_q_ff <= char_mem[rd_addr];
         sym_q_ff  <= sym_mem[rd_addr];
      end
   end

   assign char_q = char_q_ff;
   assign sym_q  = sym_q_ff;

endmodule

[rtl/mket_core.sv]
// ----------------------------------------------------------------------------
// mket_core
// Modifier, repeat and backlight state; turns a key or tick word plus the
// keymap read data into at most one result.
// ----------------------------------------------------------------------------
module mket_core #(
   parameter int REPEAT_TICKS = mket_pkg::DEF_REPEAT_TICKS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mket_pkg::cfg_type            cfg,
   input  logic                         advance,
   input  mket_pkg::stage_type          item,
   input  logic [mket_pkg::CHAR_W-1:0]  char_q,
   input  logic [mket_pkg::CHAR_W-1:0]  sym_q,
   output mket_pkg::result_type         result
);
   import mket_pkg::*;

   localparam logic [TICK_W-1:0] REPEAT_LIM = TICK_W'(REPEAT_TICKS);

   logic               symbol_mode_ff, symbol_mode_in;
   logic               caps_mode_ff, caps_mode_in;
   logic               alt_mode_ff, alt_mode_in;
   logic               key_held_ff, key_held_in;
   logic               adjust_latch_ff, adjust_latch_in;
   logic [TICK_W-1:0]  held_ticks_ff, held_ticks_in;
   logic [CHAR_W-1:0]  previous_char_ff, previous_char_in;
   logic [CHAR_W-1:0]  repeat_char_ff, repeat_char_in;
   logic [LEVEL_W-1:0] backlight_level_ff, backlight_level_in;

   logic [KEY_W-1:0]   code_key;
   logic               pressed;
   logic               press_out;
   logic               sym_next;
   logic [CHAR_W-1:0]  ch;
   logic [CHAR_W-1:0]  v;
   logic [TICK_W-1:0]  tick_next;
   logic [FLAGS_W-1:0] flags;

   assign code_key = item.code[KEY_W-1:0];
   assign pressed  = item.code[CODE_W-1];
   assign flags    = cfg.mode_flags;
   assign sym_next = (item.key == cfg.symbol_key) ? !symbol_mode_ff : symbol_mode_ff;
   assign tick_next = (held_ticks_ff < TICK_MAX) ? held_ticks_ff + 1'b1 : held_ticks_ff;

   // caps conversion applies to the character map only
   always_comb begin
      ch = char_q;
      if (caps_mode_ff && ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
         ch = ch - CASE_DIFF;
      end
   end

   always_comb begin
      symbol_mode_in     = symbol_mode_ff;
      caps_mode_in       = caps_mode_ff;
      alt_mode_in        = alt_mode_ff;
      key_held_in        = key_held_ff;
      adjust_latch_in    = adjust_latch_ff;
      held_ticks_in      = held_ticks_ff;
      previous_char_in   = previous_char_ff;
      repeat_char_in     = repeat_char_ff;
      backlight_level_in = backlight_level_ff;
      result             = '0;
      press_out          = pressed;
      v                  = CHAR_NULL;

      case (item.cmd)
         CMD_KEY: begin
            if (item.code == '0) begin
               result = '0;
            end else if (flags[FLAG_RAW]) begin
               result.valid      = 1'b1;
               result.kind       = KIND_RAW;
               result.is_pressed = pressed;
               result.raw_key    = code_key;
            end else if (code_key > GPIO_LAST_KEY) begin
               result.valid      = 1'b1;
               result.kind       = KIND_GPIO;
               result.is_pressed = pressed;
               result.gpio_index = GPIO_W'(code_key - GPIO_BASE);
            end else if (code_key == '0 || !item.row_ok) begin
               result = '0;
            end else if (item.key != cfg.symbol_key &&
                         (item.key == cfg.caps_keys[KEY_W-1:0] ||
                          item.key == cfg.caps_keys[CAPS_W-1:KEY_W])) begin
               caps_mode_in = !caps_mode_ff;
            end else if (item.key != cfg.symbol_key && item.key == cfg.alt_key) begin
               alt_mode_in = !alt_mode_ff;
            end else if (item.key != cfg.symbol_key && item.key == cfg.backspace_key) begin
               held_ticks_in = '0;
               if (pressed) begin
                  previous_char_in = CHAR_BS;
                  repeat_char_in   = CHAR_BS;
                  key_held_in      = 1'b1;
                  result.valid     = 1'b1;
                  result.kind      = KIND_PRESS;
                  result.char_code = CHAR_BS;
               end else begin
                  key_held_in = 1'b0;
               end
            end else begin
               // ordinary key, or the symbol key acting as one
               symbol_mode_in = sym_next;
               if (item.key == cfg.symbol_key && flags[FLAG_HAS_SYMBOL]) begin
                  result = '0;
               end else if (pressed && alt_mode_ff && item.key == cfg.brightness_key &&
                            flags[FLAG_BACKLIGHT]) begin
                  backlight_level_in = (backlight_level_ff != '0) ? '0 : LEVEL_FULL;
                  adjust_latch_in    = 1'b1;
                  result.valid       = 1'b1;
                  result.kind        = KIND_BRIGHT;
                  result.brightness  = backlight_level_in;
               end else if (!pressed && adjust_latch_ff) begin
                  adjust_latch_in = 1'b0;
               end else begin
                  if (item.look_ok) begin
                     v = sym_next ? sym_q : ch;
                  end
                  if (sym_next) begin
                     if (v == CHAR_SPACE) begin
                        v = CHAR_NULL;
                     end
                  end else if (flags[FLAG_HAS_SYMBOL]) begin
                     if (v == CHAR_NULL && previous_char_ff == CHAR_NULL && pressed) begin
                        v = CHAR_SPACE;
                     end
                  end else if (previous_char_ff == CHAR_NULL) begin
                     v         = CHAR_SPACE;
                     press_out = 1'b1;
                  end
                  previous_char_in = v;
                  repeat_char_in   = v;
                  key_held_in      = press_out;
                  held_ticks_in    = '0;
                  result.valid     = 1'b1;
                  result.kind      = press_out ? KIND_PRESS : KIND_RELEASE;
                  result.char_code = v;
               end
            end
         end
         CMD_TICK: begin
            held_ticks_in = tick_next;
            if (flags[FLAG_REPEAT] && key_held_ff && tick_next > REPEAT_LIM) begin
               if (previous_char_ff == CHAR_NULL || previous_char_ff == CHAR_SPACE) begin
                  key_held_in = 1'b0;
               end else begin
                  held_ticks_in    = '0;
                  result.valid     = 1'b1;
                  result.kind      = KIND_PRESS;
                  result.char_code = repeat_char_ff;
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_mode_ff     <= 1'b0;
         caps_mode_ff       <= 1'b0;
         alt_mode_ff        <= 1'b0;
         key_held_ff        <= 1'b0;
         adjust_latch_ff    <= 1'b0;
         held_ticks_ff      <= '0;
         previous_char_ff   <= '0;
         repeat_char_ff     <= '0;
         backlight_level_ff <= '0;
      end else if (advance) begin
         symbol_mode_ff     <= symbol_mode_in;
         caps_mode_ff       <= caps_mode_in;
         alt_mode_ff        <= alt_mode_in;
         key_held_ff        <= key_held_in;
         adjust_latch_ff    <= adjust_latch_in;
         held_ticks_ff      <= held_ticks_in;
         previous_char_ff   <= previous_char_in;
         repeat_char_ff     <= repeat_char_in;
         backlight_level_ff <= backlight_level_in;
      end
   end

endmodule

[rtl/matrix_key_event_translator.sv]
// ----------------------------------------------------------------------------
// matrix_key_event_translator
// Translates key-matrix FIFO bytes and millisecond ticks into character,
// GPIO, raw and backlight result words; loads keymap entries.
// ----------------------------------------------------------------------------
// Takes one input word per clock while the result side keeps taking words. The
// accepting edge reads the character and symbol maps (both synchronous memories,
// read together at the key's index) into the read stage while keymap loads
// write; the edge that moves the word out of the read stage applies the
// modifier and repeat state and fills the output register, where its result
// becomes valid. A word only moves out of the read stage when the output
// register is empty or being drained, so a held result word stalls the input
// once one more word waits in the read stage. Key bytes, ticks and loads that
// produce no result leave the output channel untouched. Unwritten keymap
// entries read back undefined.
module matrix_key_event_translator #(
   parameter int MAX_ROWS     = mket_pkg::DEF_MAX_ROWS,
   parameter int REPEAT_TICKS = mket_pkg::DEF_REPEAT_TICKS
) (
   input  logic                             clock,
   input  logic                             reset,
   mket_req_if.sink                         req_if,
   mket_rsp_if.source                       rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mket_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [mket_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [mket_pkg::APB_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import mket_pkg::*;

   localparam int TABLE_SIZE = MAX_ROWS * KEYS_PER_ROW_CODE;
   localparam int AW         = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] TABLE_LIM = IDX_W'(TABLE_SIZE);

   cfg_type           cfg;
   stage_type         stage_ff, stage_in;
   logic              stage_valid_ff;
   result_type        out_ff;
   logic              out_valid_ff;
   result_type        result;
   logic [CHAR_W-1:0] char_q;
   logic [CHAR_W-1:0] sym_q;

   logic              accept;
   logic              advance;
   logic [KEY_W-1:0]  key;
   logic [CNT_W-1:0]  row;
   logic [CNT_W-1:0]  col;
   logic [IDX_W-1:0]  lookup_idx;
   logic              load_ok;
   logic              map_wr;

   mket_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: stage moves when the output register is free or being drained
   assign advance       = stage_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !stage_valid_ff || advance;
   assign accept        = req_if.valid && req_if.ready;

   // key index, row and column from the event byte
   assign key        = req_if.event_code[KEY_W-1:0] - 1'b1;
   assign row        = div10(key);
   assign col        = CNT_W'(key - KEY_W'(row) * KEY_W'(KEYS_PER_ROW_CODE));
   assign lookup_idx = IDX_W'(row * cfg.column_count) + IDX_W'(col);

   assign load_ok = IDX_W'(req_if.map_index) < TABLE_LIM;
   assign map_wr  = accept && (req_if.cmd == CMD_LOAD) && load_ok;

   always_comb begin
      stage_in.cmd     = req_if.cmd;
      stage_in.code    = req_if.event_code;
      stage_in.key     = key;
      stage_in.row_ok  = row < cfg.row_count;
      stage_in.look_ok = (row < cfg.row_count) && (col < cfg.column_count) &&
                         (lookup_idx < TABLE_LIM);
   end

   mket_keymap #(
      .DEPTH (TABLE_SIZE),
      .AW    (AW)
   ) u_keymap (
      .clock   (clock),
      .wr_en   (map_wr),
      .wr_sel  (req_if.map_select),
      .wr_addr (req_if.map_index[AW-1:0]),
      .wr_data (req_if.map_char),
      .rd_en   (accept),
      .rd_addr (lookup_idx[AW-1:0]),
      .char_q  (char_q),
      .sym_q   (sym_q)
   );

   mket_core #(
      .REPEAT_TICKS (REPEAT_TICKS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (stage_ff),
      .char_q  (char_q),
      .sym_q   (sym_q),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         stage_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.valid;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.kind       = out_ff.kind;
   assign rsp_if.char_code  = out_ff.char_code;
   assign rsp_if.is_pressed = out_ff.is_pressed;
   assign rsp_if.gpio_index = out_ff.gpio_index;
   assign rsp_if.raw_key    = out_ff.raw_key;
   assign rsp_if.brightness = out_ff.brightness;

endmodule

[verif/mket_event_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mket_event_checker
// Watches the input, result and register ports of the key-matrix event
// translator. Keeps its own copy of the registers, modifier state and keymaps,
// works out the result word for each accepted input word, and compares every
// result word as it is taken against the oldest one still awaited.
// ----------------------------------------------------------------------------
module mket_event_checker (
   input  logic                            clock,
   input  logic                            reset,
   mket_req_if                             req_bus,
   mket_rsp_if                             rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mket_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [mket_pkg::APB_DATA_W-1:0] pwdata,
   input  logic                            pready,
   output int                              failures,
   output int                              backlog
);
   import mket_pkg::*;

   localparam int MAP_DEPTH = DEF_MAX_ROWS * KEYS_PER_ROW_CODE;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  char_code;
      logic               is_pressed;
      logic [GPIO_W-1:0]  gpio_index;
      logic [KEY_W-1:0]   raw_key;
      logic [LEVEL_W-1:0] brightness;
   } key_word_type;

   cfg_type            regs;
   logic               sym_mode, caps_mode, alt_mode, held, bright_latch;
   logic [TICK_W-1:0]  held_count;
   logic [CHAR_W-1:0]  last_char, repeat_char;
   logic [LEVEL_W-1:0] level;
   logic [CHAR_W-1:0]  char_map [MAP_DEPTH];
   logic [CHAR_W-1:0]  sym_map [MAP_DEPTH];
   key_word_type       awaited_words [$];

   function automatic logic [CHAR_W-1:0] map_read(input logic [KEY_W-1:0] k);
      int row, col, idx;
      logic [CHAR_W-1:0] v;
      row = k / KEYS_PER_ROW_CODE;
      col = k % KEYS_PER_ROW_CODE;
      if (row >= regs.row_count || col >= regs.column_count) return CHAR_NULL;
      idx = row * regs.column_count + col;
      if (idx >= MAP_DEPTH) return CHAR_NULL;
      if (sym_mode) return sym_map[idx];
      v = char_map[idx];
      if (caps_mode && v >= CHAR_LC_A && v <= CHAR_LC_Z) v = v - CASE_DIFF;
      return v;
   endfunction

   // k is the zero-based key index, already inside the rows in use
   task automatic decode_key(input logic pressed_in, input logic [KEY_W-1:0] k,
                             output bit made, output key_word_type w);
      logic              pressed;
      logic [CHAR_W-1:0] v;
      pressed = pressed_in;
      made = 0;
      w = '0;
      if (k == regs.symbol_key) begin
         sym_mode = !sym_mode;
         if (regs.mode_flags[FLAG_HAS_SYMBOL]) return;
      end else if (k == regs.caps_keys[KEY_W-1:0] ||
                   k == regs.caps_keys[CAPS_W-1:KEY_W]) begin
         caps_mode = !caps_mode;
         return;
      end else if (k == regs.alt_key) begin
         alt_mode = !alt_mode;
         return;
      end else if (k == regs.backspace_key) begin
         held_count = '0;
         held = pressed;
         if (pressed) begin
            last_char = CHAR_BS;
            repeat_char = CHAR_BS;
            made = 1;
            w.kind = KIND_PRESS;
            w.char_code = CHAR_BS;
         end
         return;
      end

      if (pressed) begin
         if (alt_mode && k == regs.brightness_key && regs.mode_flags[FLAG_BACKLIGHT]) begin
            level = (level != 0) ? '0 : LEVEL_FULL;
            bright_latch = 1;
            made = 1;
            w.kind = KIND_BRIGHT;
            w.brightness = level;
            return;
         end
      end else if (bright_latch) begin
         // first release after a brightness toggle is swallowed
         bright_latch = 0;
         return;
      end

      v = map_read(k);
      if (sym_mode) begin
         if (v == CHAR_SPACE) v = CHAR_NULL;
      end else if (regs.mode_flags[FLAG_HAS_SYMBOL]) begin
         if (v == CHAR_NULL && last_char == CHAR_NULL && pressed) v = CHAR_SPACE;
      end else if (last_char == CHAR_NULL) begin
         v = CHAR_SPACE;
         pressed = 1;
      end

      last_char = v;
      repeat_char = v;
      held = pressed;
      held_count = '0;
      made = 1;
      w.kind = pressed ? KIND_PRESS : KIND_RELEASE;
      w.char_code = v;
   endtask

   task automatic translate_word(input logic [CMD_W-1:0] cmd,
                                 input logic [CODE_W-1:0] code,
                                 input logic sel,
                                 input logic [MAP_IDX_W-1:0] idx,
                                 input logic [CHAR_W-1:0] ch,
                                 output bit made, output key_word_type w);
      logic [KEY_W-1:0] key;
      made = 0;
      w = '0;
      key = code[KEY_W-1:0];
      case (cmd)
         CMD_KEY: begin
            if (code == 0) begin
            end else if (regs.mode_flags[FLAG_RAW]) begin
               made = 1;
               w.kind = KIND_RAW;
               w.is_pressed = code[CODE_W-1];
               w.raw_key = key;
            end else if (key > GPIO_LAST_KEY) begin
               made = 1;
               w.kind = KIND_GPIO;
               w.is_pressed = code[CODE_W-1];
               w.gpio_index = GPIO_W'(key - GPIO_BASE);
            end else if (key != 0) begin
               key = key - 1'b1;
               if (key / KEYS_PER_ROW_CODE < regs.row_count)
                  decode_key(code[CODE_W-1], key, made, w);
            end
         end
         CMD_TICK: begin
            if (held_count != TICK_MAX) held_count = held_count + 1'b1;
            if (regs.mode_flags[FLAG_REPEAT] && held && held_count > DEF_REPEAT_TICKS) begin
               if (last_char == CHAR_NULL || last_char == CHAR_SPACE) begin
                  held = 0;
               end else begin
                  held_count = '0;
                  made = 1;
                  w.kind = KIND_PRESS;
                  w.char_code = repeat_char;
               end
            end
         end
         CMD_LOAD: begin
            if (idx < MAP_DEPTH) begin
               if (sel) sym_map[idx] = ch;
               else char_map[idx] = ch;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                              input logic [CHAR_W-1:0] got);
      if (got !== want) begin
         failures++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : observe
      key_word_type want, next_word;
      bit           made;
      if (reset) begin
         regs = '0;
         regs.row_count = 4;
         regs.column_count = 10;
         sym_mode = 0;
         caps_mode = 0;
         alt_mode = 0;
         held = 0;
         bright_latch = 0;
         held_count = '0;
         last_char = CHAR_NULL;
         repeat_char = CHAR_NULL;
         level = '0;
         awaited_words.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_words.size() == 0) begin
               failures++;
               $error("result word with none awaited: kind %0d char_code %0d",
                      rsp_bus.kind, rsp_bus.char_code);
            end else begin
               want = awaited_words.pop_front();
               check_field("kind", want.kind, rsp_bus.kind);
               check_field("char_code", want.char_code, rsp_bus.char_code);
               check_field("is_pressed", want.is_pressed, rsp_bus.is_pressed);
               check_field("gpio_index", want.gpio_index, rsp_bus.gpio_index);
               check_field("raw_key", want.raw_key, rsp_bus.raw_key);
               check_field("brightness", want.brightness, rsp_bus.brightness);
            end
         end

         if (psel && penable && pwrite && pready) begin
            case (paddr[APB_ADDR_W-1:2])
               REG_ROWS:   regs.row_count = pwdata[CNT_W-1:0];
               REG_COLS:   regs.column_count = pwdata[CNT_W-1:0];
               REG_SYMBOL: regs.symbol_key = pwdata[KEY_W-1:0];
               REG_CAPS:   regs.caps_keys = pwdata[CAPS_W-1:0];
               REG_ALT:    regs.alt_key = pwdata[KEY_W-1:0];
               REG_BKSP:   regs.backspace_key = pwdata[KEY_W-1:0];
               REG_BRIGHT: regs.brightness_key = pwdata[KEY_W-1:0];
               REG_MODE:   regs.mode_flags = pwdata[FLAGS_W-1:0];
               default: begin
               end
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            translate_word(req_bus.cmd, req_bus.event_code, req_bus.map_select,
                           req_bus.map_index, req_bus.map_char, made, next_word);
            if (made) awaited_words.push_back(next_word);
         end
      end
      backlog <= awaited_words.size();
   end

endmodule

[verif/tb_matrix_key_event_translator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_key_event_translator
// Drives key bytes, ticks and keymap loads into the translator under a series
// of register settings, with random gaps and result-side stalls; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_matrix_key_event_translator;
   import mket_pkg::*;

   localparam int ITEM_BUDGET   = 1600;
   localparam int PHASES        = 10;
   localparam int LONG_STALL    = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
   localparam logic [CODE_W-1:0] PRESS_BIT = 8'h80;

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite, pready;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata, prdata;

   bit      quiet, hold_output, long_done;
   int      failures, backlog, sent;
   cfg_type setting;

   mket_req_if req_bus ();
   mket_rsp_if rsp_bus ();

   matrix_key_event_translator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mket_event_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .pready   (pready),
      .failures (failures),
      .backlog  (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_matrix_key_event_translator failed");
      $finish;
   end

   // result side: random stalls, one long hold on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_output) begin
            hold_output = 0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic offer_word(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                             input logic sel, input logic [MAP_IDX_W-1:0] idx,
                             input logic [CHAR_W-1:0] ch);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.event_code <= code;
      req_bus.map_select <= sel;
      req_bus.map_index  <= idx;
      req_bus.map_char   <= ch;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   task automatic put_key(input logic [CODE_W-1:0] code);
      offer_word(CMD_KEY, code, 1'($urandom), MAP_IDX_W'($urandom), CHAR_W'($urandom));
   endtask

   task automatic put_ticks(input int n);
      repeat (n)
         offer_word(CMD_TICK, CODE_W'($urandom), 1'($urandom), MAP_IDX_W'($urandom),
                    CHAR_W'($urandom));
   endtask

   task automatic type_key(input logic [CODE_W-1:0] code);
      put_key(PRESS_BIT | code);
      put_ticks($urandom_range(0, 3));
      put_key(code);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] index,
                            input logic [APB_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // bus goes idle before the next transfer
      @(posedge clock);
   endtask

   task automatic apply_setting();
      write_reg(REG_ROWS, APB_DATA_W'(setting.row_count));
      write_reg(REG_COLS, APB_DATA_W'(setting.column_count));
      write_reg(REG_SYMBOL, APB_DATA_W'(setting.symbol_key));
      write_reg(REG_CAPS, APB_DATA_W'(setting.caps_keys));
      write_reg(REG_ALT, APB_DATA_W'(setting.alt_key));
      write_reg(REG_BKSP, APB_DATA_W'(setting.backspace_key));
      write_reg(REG_BRIGHT, APB_DATA_W'(setting.brightness_key));
      write_reg(REG_MODE, APB_DATA_W'(setting.mode_flags));
   endtask

   // wait for every awaited word, then let silent words leave the pipeline
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CODE_W-1:0] key_of(input logic [KEY_W-1:0] k);
      return {1'b0, KEY_W'(k + 1'b1)};
   endfunction

   function automatic logic [CODE_W-1:0] key_code();
      if ($urandom_range(0, 6) != 0)
         return CODE_W'($urandom_range(1, setting.row_count * KEYS_PER_ROW_CODE));
      return CODE_W'($urandom_range(1, 127));
   endfunction

   function automatic logic [CHAR_W-1:0] map_byte();
      case ($urandom_range(0, 9))
         0, 1:          return CHAR_NULL;
         2:             return CHAR_SPACE;
         3, 4, 5, 6, 7: return CHAR_LC_A + CHAR_W'($urandom_range(0, 25));
         default:       return CHAR_W'($urandom);
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] any_key(input int span);
      return KEY_W'($urandom_range(0, span));
   endfunction

   task automatic choose_setting(input int p);
      int span;
      setting = '0;
      case (p)
         0: begin
            setting.row_count = 1;
            setting.column_count = 1;
         end
         1: begin
            setting.row_count = DEF_MAX_ROWS;
            setting.column_count = KEYS_PER_ROW_CODE;
            setting.symbol_key = '1;
            setting.caps_keys = '1;
            setting.alt_key = '1;
            setting.backspace_key = '1;
            setting.brightness_key = '1;
            setting.mode_flags = '1;
            setting.mode_flags[FLAG_RAW] = 1'b0;
         end
         default: begin
            setting.row_count = CNT_W'($urandom_range(1, DEF_MAX_ROWS));
            setting.column_count = CNT_W'($urandom_range(1, KEYS_PER_ROW_CODE));
            span = setting.row_count * KEYS_PER_ROW_CODE - 1;
            setting.symbol_key = any_key(span);
            setting.caps_keys = {any_key(span), any_key(span)};
            setting.alt_key = any_key(span);
            setting.backspace_key = any_key(span);
            setting.brightness_key = any_key(span);
            setting.mode_flags = FLAGS_W'($urandom_range(0, 15));
            setting.mode_flags[FLAG_REPEAT] = p[0];
            if (p == 2) setting.mode_flags = '1;
            else if ($urandom_range(0, 2) != 0) setting.mode_flags[FLAG_RAW] = 1'b0;
         end
      endcase
   endtask

   task automatic play_sequence();
      int               pick;
      logic [CODE_W-1:0] code, mod_code;
      pick = $urandom_range(0, 99);
      code = key_code();
      if (pick < 45) begin
         type_key(code);
      end else if (pick < 60) begin
         case ($urandom_range(0, 3))
            0:       mod_code = key_of(setting.symbol_key);
            1:       mod_code = key_of(setting.caps_keys[KEY_W-1:0]);
            2:       mod_code = key_of(setting.caps_keys[CAPS_W-1:KEY_W]);
            default: mod_code = key_of(setting.alt_key);
         endcase
         put_key(PRESS_BIT | mod_code);
         repeat ($urandom_range(1, 3)) type_key(key_code());
         put_key(mod_code);
      end else if (pick < 68) begin
         put_key(PRESS_BIT | key_of(setting.alt_key));
         put_key(PRESS_BIT | key_of(setting.brightness_key));
         put_key($urandom_range(0, 1) ? key_of(setting.brightness_key) : code);
         put_key(key_of(setting.alt_key));
      end else if (pick < 73) begin
         put_key(PRESS_BIT | key_of(setting.backspace_key));
         put_ticks($urandom_range(0, 4));
         put_key(key_of(setting.backspace_key));
      end else if (pick < 76 && !long_done && setting.mode_flags[FLAG_REPEAT]) begin
         // hold up to or across the repeat threshold, once per run
         long_done = 1;
         put_key(PRESS_BIT | code);
         put_ticks($urandom_range(DEF_REPEAT_TICKS - 5, DEF_REPEAT_TICKS + 40));
         put_key(code);
      end else if (pick < 86) begin
         put_key(CODE_W'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         offer_word(CMD_LOAD, CODE_W'($urandom), 1'($urandom), MAP_IDX_W'($urandom),
                    map_byte());
      end else if (pick < 94) begin
         offer_word(CMD_SPARE, CODE_W'($urandom), 1'($urandom), MAP_IDX_W'($urandom),
                    CHAR_W'($urandom));
      end else begin
         put_ticks($urandom_range(1, 5));
      end
   endtask

   initial begin : stimulus
      int phase_end;
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_KEY;
      req_bus.event_code <= '0;
      req_bus.map_select <= 1'b0;
      req_bus.map_index  <= '0;
      req_bus.map_char   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every keymap entry is written before any key can read it
      for (int i = 0; i < DEF_MAX_ROWS * KEYS_PER_ROW_CODE; i++) begin
         offer_word(CMD_LOAD, CODE_W'($urandom), 1'b0, MAP_IDX_W'(i), map_byte());
         offer_word(CMD_LOAD, CODE_W'($urandom), 1'b1, MAP_IDX_W'(i), map_byte());
      end
      settle();

      setting = '0;
      setting.row_count = DEF_MAX_ROWS;
      setting.column_count = KEYS_PER_ROW_CODE;
      setting.symbol_key = 1;
      setting.caps_keys = {7'd3, 7'd2};
      setting.alt_key = 4;
      setting.backspace_key = 5;
      setting.brightness_key = 6;
      setting.mode_flags = '1;
      setting.mode_flags[FLAG_RAW] = 1'b0;
      apply_setting();

      put_key('0);                          // empty FIFO byte
      offer_word(CMD_SPARE, '1, 1'b1, '1, '1);
      put_key(PRESS_BIT | {1'b0, GPIO_BASE});
      put_key(8'd127);
      put_key(PRESS_BIT);                   // key code zero
      put_key(PRESS_BIT | 8'd91);           // row past the rows in use
      put_key(PRESS_BIT | key_of(setting.backspace_key));
      put_key(key_of(setting.backspace_key));
      put_key(PRESS_BIT | key_of(setting.alt_key));
      put_key(PRESS_BIT | key_of(setting.brightness_key));
      put_key(key_of(setting.brightness_key));
      put_key(PRESS_BIT | key_of(setting.brightness_key));
      put_key(8'd10);
      put_key(key_of(setting.alt_key));
      put_key(PRESS_BIT | key_of(setting.caps_keys[CAPS_W-1:KEY_W]));
      type_key(8'd12);
      put_key(key_of(setting.caps_keys[CAPS_W-1:KEY_W]));
      put_key(PRESS_BIT | key_of(setting.symbol_key));
      type_key(8'd13);
      put_key(key_of(setting.symbol_key));
      settle();

      // column past the columns in use reads as null
      setting.column_count = 3;
      write_reg(REG_COLS, APB_DATA_W'(setting.column_count));
      put_key(PRESS_BIT | 8'd10);
      settle();

      setting.mode_flags = '0;
      setting.mode_flags[FLAG_RAW] = 1'b1;
      write_reg(REG_MODE, APB_DATA_W'(setting.mode_flags));
      put_key('0);
      put_key('1);
      put_key(8'd1);
      settle();

      // symbol key without the symbol flag falls through to a lookup
      setting.mode_flags = '0;
      write_reg(REG_MODE, APB_DATA_W'(setting.mode_flags));
      put_key(PRESS_BIT | key_of(setting.symbol_key));
      put_key(key_of(setting.symbol_key));
      settle();

      for (int p = 0; p < PHASES; p++) begin
         choose_setting(p);
         apply_setting();
         quiet = (p == PHASES - 1);
         if (p == 2) hold_output = 1;
         // spread what is left of the word budget over the remaining phases
         phase_end = sent + (ITEM_BUDGET - sent) / (PHASES - p);
         while (sent < phase_end) play_sequence();
         settle();
      end

      if (failures == 0) begin
         $display("tb_matrix_key_event_translator passed");
      end else begin
         $display("tb_matrix_key_event_translator failed");
      end
      $finish;
   end

endmodule

[matrix_key_event_translator.f]
rtl/mket_pkg.sv
rtl/mket_if.sv
rtl/mket_csr.sv
rtl/mket_keymap.sv
rtl/mket_core.sv
rtl/matrix_key_event_translator.sv
verif/mket_event_checker.sv
verif/tb_matrix_key_event_translator.sv
